### sv/npb_pkg.sv
// Shared types, codes and helpers for the n-gram presence bitmap.
package npb_pkg;

  localparam int SYM_W      = 8;
  localparam int LEN_W      = 4;
  localparam int SPACE_W    = 21;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [SYM_W-1:0]   SYM_MAX_RST     = 8'd255;
  localparam logic [LEN_W-1:0]   NGRAM_LEN_RST   = 4'd2;
  localparam logic [SPACE_W-1:0] INDEX_SPACE_RST = 21'd65537;

  // Operation codes on the input side; the result kind reuses the same codes.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_COUNT  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYMBOL_MAX  = 2'd0,
    REG_NGRAM_LEN   = 2'd1,
    REG_INDEX_SPACE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_COUNT_OUT
  } state_t;

  typedef struct packed {
    logic complete;
    logic fault;
  } gram_status_t;

  // Set bits in one byte, folded in pairs, nibbles, then the byte.
  function automatic logic [3:0] byte_pop(input logic [7:0] v);
    logic [7:0] a;
    logic [7:0] b;
    a = (v & 8'h55) + ((v >> 1) & 8'h55);
    b = (a & 8'h33) + ((a >> 2) & 8'h33);
    byte_pop = 4'((b & 8'h0f) + ((b >> 4) & 8'h0f));
  endfunction

endpackage

### sv/npb_gram.sv
// Mixed-radix index folding with range checks for the n-gram in progress.
module npb_gram import npb_pkg::*; #(
  parameter int INDEX_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  step,
  input  logic [SYM_W-1:0]      symbol,
  input  logic [SYM_W-1:0]      symbol_max,
  input  logic [LEN_W-1:0]      ngram_len,
  input  logic [SPACE_W-1:0]    index_space,
  output gram_status_t          status,
  output logic [INDEX_BITS-1:0] index
);

  localparam int PROD_W = INDEX_BITS + SYM_W + 1;
  localparam int LIM_W  = INDEX_BITS + 1;
  localparam logic [31:0] MAP_SIZE = 32'd1 << INDEX_BITS;

  logic [INDEX_BITS-1:0] acc;
  logic [LEN_W-1:0]      seen;
  logic                  fault;

  logic [SYM_W:0]        radix;
  logic [PROD_W-1:0]     prod;
  logic [LIM_W-1:0]      limit;
  logic                  sym_bad;
  logic                  idx_bad;
  logic                  fault_next;
  logic [INDEX_BITS-1:0] acc_next;
  logic [LEN_W-1:0]      need;
  logic [LEN_W-1:0]      seen_next;

  always_comb begin
    radix = {1'b0, symbol_max} + (SYM_W + 1)'(1);
    prod  = PROD_W'(acc) * PROD_W'(radix) + PROD_W'(symbol);
    if (32'(index_space) < MAP_SIZE) begin
      limit = LIM_W'(index_space);
    end else begin
      limit = LIM_W'(MAP_SIZE);
    end
    sym_bad    = symbol > symbol_max;
    idx_bad    = prod >= PROD_W'(limit);
    fault_next = fault | sym_bad | idx_bad;
    acc_next   = fault_next ? acc : INDEX_BITS'(prod);
    need       = (ngram_len == '0) ? LEN_W'(1) : ngram_len;
    seen_next  = seen + LEN_W'(1);
    status.complete = seen_next >= need;
    status.fault    = fault_next;
    index           = acc_next;
  end

  // Drop the n-gram on completion or on a register write.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc   <= '0;
      seen  <= '0;
      fault <= 1'b0;
    end else if (step) begin
      if (status.complete) begin
        acc   <= '0;
        seen  <= '0;
        fault <= 1'b0;
      end else begin
        acc   <= acc_next;
        seen  <= seen_next;
        fault <= fault_next;
      end
    end
  end

endmodule

### sv/npb_mem.sv
// Bitmap word memory with registered read and a clearing sweep after reset.
module npb_mem #(
  parameter int ADDR_W    = 15,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  output logic                 busy
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]    clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (&clr_addr) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/npb_scan.sv
// Population count walk over the bitmap, one word read per cycle.
module npb_scan import npb_pkg::*; #(
  parameter int INDEX_BITS = 20,
  parameter int WORD_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [INDEX_BITS-3:0] bytes,
  output logic                  rd_en,
  output logic [INDEX_BITS-$clog2(WORD_BITS)-1:0] rd_addr,
  input  logic [WORD_BITS-1:0]  rd_data,
  output logic                  done,
  output logic [INDEX_BITS:0]   set_count
);

  localparam int BPW     = WORD_BITS / 8;
  localparam int BPW_LOG = $clog2(BPW);
  localparam int ADDR_W  = INDEX_BITS - $clog2(WORD_BITS);
  localparam int BYTES_W = INDEX_BITS - 2;
  localparam int REM_W   = BPW_LOG + 1;
  localparam int CNT_W   = INDEX_BITS + 1;

  logic               active;
  logic [BYTES_W-1:0] base;
  logic               d_valid;
  logic [REM_W-1:0]   d_rem;
  logic [CNT_W-1:0]   total;

  logic [BYTES_W-1:0] rem;
  logic [REM_W-1:0]   rem_clip;
  logic [CNT_W-1:0]   word_sum;

  always_comb begin
    rd_en    = active && (base < bytes);
    rd_addr  = base[BPW_LOG +: ADDR_W];
    rem      = bytes - base;
    rem_clip = (rem >= BYTES_W'(BPW)) ? REM_W'(BPW) : rem[REM_W-1:0];
    done     = active && !rd_en && !d_valid;
    word_sum = '0;
    for (int j = 0; j < BPW; j++) begin
      if (REM_W'(j) < d_rem) begin
        word_sum = word_sum + CNT_W'(byte_pop(rd_data[8*j +: 8]));
      end
    end
    set_count = total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      d_valid <= rd_en;
      if (start) begin
        active <= 1'b1;
      end else if (done) begin
        active <= 1'b0;
      end
    end
  end

  // Advance the byte cursor and hold the byte count of the word in flight.
  always_ff @(posedge clk) begin
    d_rem <= rem_clip;
    if (start) begin
      base  <= '0;
      total <= '0;
    end else begin
      if (rd_en) begin
        base <= base + BYTES_W'(BPW);
      end
      if (d_valid) begin
        total <= total + word_sum;
      end
    end
  end

endmodule

### sv/ngram_presence_bitmap.sv
// Top level of the n-gram presence bitmap: channels, configuration and control sequencer.
// Input stream (s_*): one symbol per transaction; s_tuser carries the operation
//   (insert, lookup, population count), s_tdata the symbol. The transaction that
//   brings the ngram_len-th symbol completes the n-gram; its operation decides.
// Output stream (m_*): one result per completed n-gram and per count request.
// Configuration channel (cfg_*): cfg_index selects symbol_max, ngram_len or
//   index_space; a write abandons the n-gram in progress. Write only while idle.
// Sequencing: a symbol that does not complete an n-gram leaves the sequencer idle. A
//   completing symbol reads its bitmap word at the accepting edge; in ST_ACCESS it
//   writes back or answers once the output register is free, and the input is held
//   off until then. A count reads one word per cycle on the single read port:
//   N = ceil(bytes / (WORD_BITS/8)) reads, then its result loads from ST_COUNT_OUT,
//   with the input held off throughout.
// Reset: rst clears control state, then a sweep zeroes the bitmap one word per cycle,
//   all 2**INDEX_BITS / WORD_BITS words (32768 at the defaults), with s_tready low.
//   Configuration writes are taken during the sweep.
// Backpressure: a result waits in the output register while m_tready is low.
//   Symbols that do not complete an n-gram keep flowing; a completing symbol or a
//   count is taken, then holds the input off until its result can load.
module ngram_presence_bitmap import npb_pkg::*; #(
  parameter int INDEX_BITS = 20,
  parameter int WORD_BITS  = 32,
  localparam int DATA_W    = ((3 * INDEX_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,    // [7:0] symbol
  input  logic [OP_W-1:0]       s_tuser,    // [1:0] operation
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DATA_W-1:0]     m_tdata,    // found, bit_index, set_count, bytes_scanned, zero pad
  output logic [OP_W:0]         m_tuser,    // [1:0] kind, [2] error
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int POS_W   = $clog2(WORD_BITS);
  localparam int ADDR_W  = INDEX_BITS - POS_W;
  localparam int CNT_W   = INDEX_BITS + 1;
  localparam int BYTES_W = INDEX_BITS - 2;
  localparam logic [31:0] MAX_BYTES = 32'd1 << (INDEX_BITS - 3);

  // Configuration registers.
  logic [SYM_W-1:0]   symbol_max;
  logic [LEN_W-1:0]   ngram_len;
  logic [SPACE_W-1:0] index_space;
  logic               cfg_hit;

  // Sequencer and pending access.
  state_t                state;
  state_t                state_next;
  op_t                   op;
  op_t                   pend_op;
  logic                  pend_fault;
  logic [INDEX_BITS-1:0] pend_idx;

  // Gram unit.
  gram_status_t          gstat;
  logic [INDEX_BITS-1:0] gidx;
  logic                  s_accept;
  logic                  gram_step;

  // Memory and scan.
  logic                  acc_rd_en;
  logic                  wr_en;
  logic                  mem_rd_en;
  logic [ADDR_W-1:0]     mem_rd_addr;
  logic [WORD_BITS-1:0]  rd_data;
  logic [WORD_BITS-1:0]  wr_data;
  logic                  mem_busy;
  logic                  scan_start;
  logic                  scan_rd_en;
  logic [ADDR_W-1:0]     scan_addr;
  logic                  scan_done;
  logic [CNT_W-1:0]      scan_total;
  logic [31:0]           space_bytes;
  logic [BYTES_W-1:0]    scan_bytes;

  // Result register.
  logic                  out_free;
  logic                  out_load;
  op_t                   kind_o;
  logic                  error_o;
  logic                  found_o;
  logic [INDEX_BITS-1:0] bidx_o;
  logic [CNT_W-1:0]      cnt_o;
  logic [BYTES_W-1:0]    bytes_o;
  op_t                   kind_n;
  logic                  error_n;
  logic                  found_n;
  logic [INDEX_BITS-1:0] bidx_n;
  logic [CNT_W-1:0]      cnt_n;
  logic [BYTES_W-1:0]    bytes_n;

  // Configuration: always ready; a write to a known register drops the n-gram.
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_SYMBOL_MAX ||
                                   cfg_index == REG_NGRAM_LEN ||
                                   cfg_index == REG_INDEX_SPACE);

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_max  <= SYM_MAX_RST;
      ngram_len   <= NGRAM_LEN_RST;
      index_space <= INDEX_SPACE_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SYMBOL_MAX:  symbol_max  <= cfg_data[SYM_W-1:0];
        REG_NGRAM_LEN:   ngram_len   <= cfg_data[LEN_W-1:0];
        REG_INDEX_SPACE: index_space <= cfg_data[SPACE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side: take items only in idle and after the clearing sweep.
  assign s_tready  = (state == ST_IDLE) && !mem_busy;
  assign s_accept  = s_tvalid && s_tready;
  assign op        = op_t'(s_tuser);
  assign gram_step = s_accept && (op == OP_INSERT || op == OP_LOOKUP);
  assign out_free  = !m_tvalid || m_tready;

  npb_gram #(
    .INDEX_BITS (INDEX_BITS)
  ) u_gram (
    .clk         (clk),
    .rst         (rst),
    .clear       (cfg_hit),
    .step        (gram_step),
    .symbol      (s_tdata),
    .symbol_max  (symbol_max),
    .ngram_len   (ngram_len),
    .index_space (index_space),
    .status      (gstat),
    .index       (gidx)
  );

  // Count scan length: floor(index_space / 8) bytes, clipped to the bitmap.
  always_comb begin
    space_bytes = 32'(index_space >> 3);
    scan_bytes  = (space_bytes > MAX_BYTES) ? BYTES_W'(MAX_BYTES) : BYTES_W'(space_bytes);
  end

  npb_scan #(
    .INDEX_BITS (INDEX_BITS),
    .WORD_BITS  (WORD_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .bytes     (scan_bytes),
    .rd_en     (scan_rd_en),
    .rd_addr   (scan_addr),
    .rd_data   (rd_data),
    .done      (scan_done),
    .set_count (scan_total)
  );

  // One read port shared by the scan and the n-gram access; they never overlap.
  assign mem_rd_en   = acc_rd_en || scan_rd_en;
  assign mem_rd_addr = scan_rd_en ? scan_addr : gidx[INDEX_BITS-1:POS_W];
  assign wr_data     = rd_data | (WORD_BITS'(1) << pend_idx[POS_W-1:0]);

  npb_mem #(
    .ADDR_W    (ADDR_W),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (pend_idx[INDEX_BITS-1:POS_W]),
    .wr_data (wr_data),
    .busy    (mem_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: the write-back lands before the next read can issue, so a
  // following access to the same word always sees the updated data.
  always_comb begin
    state_next = state;
    acc_rd_en  = 1'b0;
    scan_start = 1'b0;
    out_load   = 1'b0;
    wr_en      = 1'b0;
    kind_n     = pend_op;
    error_n    = pend_fault;
    found_n    = 1'b0;
    bidx_n     = pend_fault ? '0 : pend_idx;
    cnt_n      = '0;
    bytes_n    = '0;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          case (op)
            OP_INSERT, OP_LOOKUP: begin
              if (gstat.complete) begin
                acc_rd_en  = 1'b1;
                state_next = ST_ACCESS;
              end
            end
            OP_COUNT: begin
              scan_start = 1'b1;
              state_next = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_ACCESS: begin
        found_n = (pend_op == OP_LOOKUP) && !pend_fault && rd_data[pend_idx[POS_W-1:0]];
        if (out_free) begin
          out_load   = 1'b1;
          wr_en      = (pend_op == OP_INSERT) && !pend_fault;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_COUNT_OUT;
        end
      end
      ST_COUNT_OUT: begin
        kind_n  = OP_COUNT;
        error_n = 1'b0;
        bidx_n  = '0;
        cnt_n   = scan_total;
        bytes_n = scan_bytes;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the completing item's operation, fault and index for the access cycle.
  always_ff @(posedge clk) begin
    if (acc_rd_en) begin
      pend_op    <= op;
      pend_fault <= gstat.fault;
      pend_idx   <= gidx;
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_o  <= kind_n;
      error_o <= error_n;
      found_o <= found_n;
      bidx_o  <= bidx_n;
      cnt_o   <= cnt_n;
      bytes_o <= bytes_n;
    end
  end

  assign m_tdata = DATA_W'({bytes_o, cnt_o, bidx_o, found_o});
  assign m_tuser = {error_o, kind_o};

endmodule

### sv/npb_checker.sv
// Port-level checks of the n-gram presence bitmap, bound to the top level.
module npb_checker import npb_pkg::*; #(
  parameter int INDEX_BITS = 20,
  localparam int DATA_W    = ((3 * INDEX_BITS + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata,
  input logic [OP_W:0]     m_tuser
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // An errored n-gram reports no index and no hit.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[OP_W] |-> !m_tdata[0] && (m_tdata[INDEX_BITS:1] == '0))
    else $error("errored result carries index or hit");

  // Only a lookup may report a hit, and a count never errors.
  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[OP_W-1:0] != OP_LOOKUP) |->
      !m_tdata[0] && !(m_tuser[OP_W-1:0] == OP_COUNT && m_tuser[OP_W]))
    else $error("bad fields for result kind");

  // No result right after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // The clearing sweep blocks input after reset.
  a_clear_blocks: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input accepted during clearing sweep");

endmodule

bind ngram_presence_bitmap npb_checker #(.INDEX_BITS(INDEX_BITS)) u_npb_checker (.*);

### tb/sv/ngram_bitmap_watch.sv
`timescale 1ns / 100ps
// Channel watcher for the n-gram presence bitmap: folds symbols, predicts answers, compares.
module ngram_bitmap_watch import npb_pkg::*; #(
  parameter int RES_W = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [SYM_W-1:0]      s_tdata,
  input  logic [OP_W-1:0]       s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [RES_W-1:0]      m_tdata,
  input  logic [OP_W:0]         m_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    waiting,
  output int                    inserts_seen,
  output int                    lookups_seen,
  output int                    hits_seen,
  output int                    counts_seen,
  output int                    errors_seen
);

  localparam int MAP_BITS = 1 << 20;

  typedef struct packed {
    logic [OP_W-1:0] kind;
    logic            error;
    logic            found;
    logic [19:0]     bit_index;
    logic [20:0]     set_count;
    logic [17:0]     bytes_scanned;
  } answer_t;

  answer_t           answers_due [$];
  bit                presence_map [0:MAP_BITS-1];
  int unsigned       marked_bits [$];   // every index set so far, each once

  logic [SYM_W-1:0]   cfg_sym_max = SYM_MAX_RST;
  logic [LEN_W-1:0]   cfg_len     = NGRAM_LEN_RST;
  logic [SPACE_W-1:0] cfg_space   = INDEX_SPACE_RST;

  longint unsigned    gram_acc;
  logic [LEN_W-1:0]   gram_seen  = '0;
  logic               gram_fault = 1'b0;
  int                 result_no;

  function automatic void clear_gram();
    gram_acc   = 0;
    gram_seen  = '0;
    gram_fault = 1'b0;
  endfunction

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    fail_count++;
    if (fail_count <= 40)
      $display("result %0d: %s is %0h, %0h was due", result_no, what, got, want);
  endtask

  // Fold one symbol or run a count; queue the answer the transaction causes, if any.
  task automatic fold_and_answer(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
    answer_t         a;
    longint unsigned grown;
    longint unsigned limit;
    longint unsigned bytes;
    int unsigned     total;
    int unsigned     need;
    a = '0;
    case (op)
      OP_COUNT: begin
        bytes = cfg_space / 8;
        if (bytes > MAP_BITS / 8) bytes = MAP_BITS / 8;
        total = 0;
        foreach (marked_bits[i])
          if (marked_bits[i] < bytes * 8) total++;
        a.kind          = OP_COUNT;
        a.set_count     = total[20:0];
        a.bytes_scanned = bytes[17:0];
        answers_due.push_back(a);
      end
      OP_INSERT, OP_LOOKUP: begin
        need = (cfg_len == 0) ? 1 : cfg_len;
        if (!gram_fault) begin
          if (sym > cfg_sym_max) begin
            gram_fault = 1'b1;
          end else begin
            grown = gram_acc * (longint'(cfg_sym_max) + 1) + sym;
            limit = (cfg_space < MAP_BITS) ? cfg_space : MAP_BITS;
            if (grown >= limit) gram_fault = 1'b1;
            else gram_acc = grown;
          end
        end
        gram_seen = gram_seen + 1'b1;
        if (gram_seen < need) return;
        a.kind = op;
        if (gram_fault) begin
          a.error = 1'b1;
        end else begin
          a.bit_index = gram_acc[19:0];
          if (op == OP_INSERT) begin
            if (!presence_map[gram_acc]) begin
              presence_map[gram_acc] = 1'b1;
              marked_bits.push_back(32'(gram_acc));
            end
          end else begin
            a.found = presence_map[gram_acc];
          end
        end
        clear_gram();
        answers_due.push_back(a);
      end
      default: ;  // no answer, no state change
    endcase
  endtask

  task automatic check_answer();
    answer_t want;
    result_no++;
    if (answers_due.size() == 0) begin
      report("result with none due, kind", m_tuser[1:0], 0);
      return;
    end
    want = answers_due.pop_front();
    if (m_tuser[1:0] !== want.kind) report("kind", m_tuser[1:0], want.kind);
    if (m_tuser[2] !== want.error) report("error", m_tuser[2], want.error);
    if (m_tdata[0] !== want.found) report("found", m_tdata[0], want.found);
    if (m_tdata[20:1] !== want.bit_index) report("bit_index", m_tdata[20:1], want.bit_index);
    if (m_tdata[41:21] !== want.set_count) report("set_count", m_tdata[41:21], want.set_count);
    if (m_tdata[59:42] !== want.bytes_scanned)
      report("bytes_scanned", m_tdata[59:42], want.bytes_scanned);
    case (want.kind)
      OP_INSERT: inserts_seen++;
      OP_LOOKUP: begin
        lookups_seen++;
        if (want.found) hits_seen++;
      end
      default: counts_seen++;
    endcase
    if (want.error) errors_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYMBOL_MAX: begin
            cfg_sym_max = cfg_data[SYM_W-1:0];
            clear_gram();
          end
          REG_NGRAM_LEN: begin
            cfg_len = cfg_data[LEN_W-1:0];
            clear_gram();
          end
          REG_INDEX_SPACE: begin
            cfg_space = cfg_data;
            clear_gram();
          end
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) check_answer();
      if (s_tvalid && s_tready) fold_and_answer(s_tuser, s_tdata);
      waiting = answers_due.size();
    end
  end

endmodule

### tb/sv/tb_ngram_presence_bitmap.sv
`timescale 1ns / 100ps
// Testbench top for the n-gram presence bitmap: reset, stimulus by settings, and the verdict.
module tb_ngram_presence_bitmap;
  import npb_pkg::*;

  localparam int              RES_W        = ((3 * 20 + 7) / 8) * 8;
  localparam logic [OP_W-1:0] OP_IGNORED   = 2'd3;
  localparam int              NUM_SETTINGS = 13;
  localparam int              PER_SETTING  = 145;  // folded symbols and counts per setting
  localparam int              SETTLE       = 8;    // cycles after the last answer before a write
  localparam longint          TIMEOUT_NS   = 60_000_000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [SYM_W-1:0]      s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [RES_W-1:0]      m_tdata;
  logic [OP_W:0]         m_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int waiting;
  int inserts_seen;
  int lookups_seen;
  int hits_seen;
  int counts_seen;
  int errors_seen;

  int items_sent;     // transactions that fold a symbol or count; ignored ones excluded
  int settings_done;
  int gap_odds;       // 0: sender never idles, else one chance in gap_odds per transaction
  int stall_odds;     // same for the receiver, per cycle

  always #10 clk = ~clk;

  ngram_presence_bitmap u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ngram_bitmap_watch #(.RES_W(RES_W)) u_watch (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .waiting      (waiting),
    .inserts_seen (inserts_seen),
    .lookups_seen (lookups_seen),
    .hits_seen    (hits_seen),
    .counts_seen  (counts_seen),
    .errors_seen  (errors_seen)
  );

  // All tasks below start at a falling edge, drive only there, and return at a falling edge.

  // Offer one transaction on the input stream; hold it until accepted.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= sym;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (op != OP_IGNORED) items_sent++;
  endtask

  // Drop the input valid, hold the sender until every answer is in, then let
  // a partial fold settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Write all three registers while idle. Random upper bits on the narrow
  // registers check that only their own width is taken.
  task automatic apply_setting(input logic [SYM_W-1:0] sm, input logic [LEN_W-1:0] len,
                               input logic [SPACE_W-1:0] space);
    drain_results();
    write_reg(REG_SYMBOL_MAX, CFG_DATA_W'(($urandom << SYM_W) | sm));
    write_reg(REG_NGRAM_LEN, CFG_DATA_W'(($urandom << LEN_W) | len));
    write_reg(REG_INDEX_SPACE, space);
    settings_done++;
  endtask

  // Pick a symbol for position k of an n-gram. Styles: all at the largest
  // symbol, leading zeros so long grams stay in range, a tiny alphabet so
  // lookups hit earlier inserts, any byte so out-of-range symbols show up.
  function automatic logic [SYM_W-1:0] gram_symbol(input logic [SYM_W-1:0] sm, input int style,
                                                   input int k, input int need);
    case (style)
      0:       return sm;
      1:       return (k < need / 2) ? 8'd0 : SYM_W'($urandom_range(0, (sm < 3) ? sm : 3));
      2, 3, 4: return SYM_W'($urandom_range(0, (sm < 3) ? sm : 3));
      5:       return SYM_W'($urandom_range(0, 255));
      default: return SYM_W'($urandom_range(0, sm));
    endcase
  endfunction

  // Register settings, extremes first: radix one, zero length, long grams
  // that overflow, a zero index space, and spaces past the bitmap.
  task automatic choose_setting(input int p, output logic [SYM_W-1:0] sm,
                                output logic [LEN_W-1:0] len, output logic [SPACE_W-1:0] space);
    case (p)
      0:  begin sm = 8'd255; len = 4'd2;  space = 21'd65537;   end
      1:  begin sm = 8'd0;   len = 4'd8;  space = 21'd1;       end
      2:  begin sm = 8'd1;   len = 4'd8;  space = 21'd256;     end
      3:  begin sm = 8'd3;   len = 4'd4;  space = 21'd200;     end
      4:  begin sm = 8'd15;  len = 4'd5;  space = 21'd1048576; end
      5:  begin sm = 8'd255; len = 4'd1;  space = 21'd1;       end
      6:  begin sm = 8'd9;   len = 4'd0;  space = 21'd10;      end
      7:  begin sm = 8'd2;   len = 4'd15; space = 21'd2097151; end
      8:  begin sm = 8'd255; len = 4'd3;  space = 21'd0;       end
      9:  begin sm = 8'd100; len = 4'd3;  space = 21'd1030301; end
      10: begin
        sm    = SYM_W'($urandom_range(0, 255));
        len   = LEN_W'($urandom_range(1, 8));
        space = SPACE_W'($urandom_range(1, 1 << 20));
      end
      11: begin
        sm    = SYM_W'($urandom_range(0, 255));
        len   = LEN_W'($urandom_range(0, 15));
        space = SPACE_W'($urandom_range(0, 2097151));
      end
      default: begin sm = 8'd7; len = 4'd3; space = 21'd512; end
    endcase
  endtask

  // One setting: mostly whole n-grams with random content, with ignored
  // transactions and counts dropped in between, sometimes inside a gram.
  task automatic run_setting(input int p);
    logic [SYM_W-1:0]   sm;
    logic [LEN_W-1:0]   len;
    logic [SPACE_W-1:0] space;
    logic [OP_W-1:0]    op;
    int                 need;
    int                 counts_left;
    int                 start;
    int                 style;
    bit                 paused;
    choose_setting(p, sm, len, space);
    apply_setting(sm, len, space);
    need        = (len == 0) ? 1 : len;
    // A count walks the whole space; keep wide-space counts rare.
    counts_left = (space <= 16384) ? 10 : 2;
    start       = items_sent;
    paused      = 1'b0;
    while (items_sent - start < PER_SETTING) begin
      style = $urandom_range(0, 9);
      for (int k = 0; k < need; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          if (counts_left > 0 && $urandom_range(0, 1) == 1) begin
            send_item(OP_COUNT, SYM_W'($urandom));
            counts_left--;
          end else begin
            send_item(OP_IGNORED, SYM_W'($urandom));
          end
        end
        // Only the completing transaction's operation matters; vary the rest.
        op = $urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP;
        send_item(op, gram_symbol(sm, style, k, need));
      end
      if (!paused && items_sent - start >= PER_SETTING / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    // Leave a gram unfinished now and then; the next register write drops it.
    if (need > 1 && $urandom_range(0, 1) == 1) send_item(OP_LOOKUP, gram_symbol(sm, 2, 0, need));
  endtask

  // Receiver: stall in bursts, at the odds of the current setting.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = OP_INSERT;
    cfg_valid  = 1'b0;
    cfg_index  = REG_SYMBOL_MAX;
    cfg_data   = '0;
    gap_odds   = 4;
    stall_odds = 4;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset settings (radix 256, pairs, space 65537).
    // The first transaction waits out the clearing sweep.
    send_item(OP_INSERT, 8'd0);      // smallest index
    send_item(OP_INSERT, 8'd0);
    send_item(OP_INSERT, 8'd255);    // largest symbols, index 65535
    send_item(OP_INSERT, 8'd255);
    send_item(OP_LOOKUP, 8'd0);
    send_item(OP_LOOKUP, 8'd0);
    send_item(OP_LOOKUP, 8'd1);      // never inserted
    send_item(OP_LOOKUP, 8'd2);
    send_item(OP_IGNORED, 8'hAA);    // operation three: no answer
    send_item(OP_COUNT, 8'h5A);
    // Count inside a gram; the completing lookup decides the answer kind.
    send_item(OP_INSERT, 8'd255);
    send_item(OP_COUNT, 8'h00);
    send_item(OP_LOOKUP, 8'd255);

    // Radix 10, triples, space 1000.
    apply_setting(8'd9, 4'd3, 21'd1000);
    send_item(OP_INSERT, 8'd9);      // 999, last in range
    send_item(OP_INSERT, 8'd9);
    send_item(OP_INSERT, 8'd9);
    send_item(OP_INSERT, 8'd12);     // too large in first position
    send_item(OP_INSERT, 8'd0);
    send_item(OP_INSERT, 8'd0);
    send_item(OP_LOOKUP, 8'd9);
    send_item(OP_LOOKUP, 8'd9);
    send_item(OP_LOOKUP, 8'd9);
    // Start a gram, then shrink the space: the write abandons it.
    send_item(OP_LOOKUP, 8'd7);
    drain_results();
    write_reg(REG_INDEX_SPACE, 21'd500);
    send_item(OP_LOOKUP, 8'd5);      // 500 reaches the space: fault
    send_item(OP_LOOKUP, 8'd0);
    send_item(OP_LOOKUP, 8'd0);

    // Random part, one setting after another; the last without any idling.
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p == NUM_SETTINGS - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
        stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
      end
      run_setting(p);
    end
    s_tvalid <= 1'b0;

    while (waiting != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Ran %0d transactions over %0d register settings, extremes included.",
             items_sent, settings_done);
    $display("Answers: %0d inserts, %0d lookups (%0d hits), %0d counts, %0d out of range.",
             inserts_seen, lookups_seen, hits_seen, counts_seen, errors_seen);
    if (fail_count == 0 && waiting == 0) begin
      $display("[ngram_presence_bitmap] OK");
    end else begin
      $display("[ngram_presence_bitmap] ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("[ngram_presence_bitmap] ERROR");
    $finish;
  end

endmodule

### files.f
sv/npb_pkg.sv
sv/npb_gram.sv
sv/npb_mem.sv
sv/npb_scan.sv
sv/ngram_presence_bitmap.sv
sv/npb_checker.sv
tb/sv/ngram_bitmap_watch.sv
tb/sv/tb_ngram_presence_bitmap.sv
